@@ hw/rtl/tplc_pkg.sv @@
// Package for the two-object peak-level centroid core.
// Holds field layout, register indexes, state types and the command and status structs.
// Depends on nothing; every other file of the core imports it.
package tplc_pkg;

  localparam int WORD_W     = 32;
  localparam int HALF_W     = 16;
  localparam int NUM_OBJ    = 2;
  localparam int LEVEL_W    = 3;
  localparam int OFFSET_W   = 7;
  localparam int OFFSET_MAX = 64;
  localparam int SIZE_W     = 13;
  localparam int CENTER_W   = 17;
  localparam int TOTAL_W    = 2;
  localparam int CFG_IDX_W  = 2;

  localparam int FLAG_R_BIT = 7;
  localparam int FLAG_U_BIT = 15;
  localparam int LEVEL_R_LSB = 4;
  localparam int LEVEL_U_LSB = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 13'd480;

  localparam logic [LEVEL_W-1:0] PEAK_START = 3'd1;

  typedef struct packed {
    logic               flag;
    logic [LEVEL_W-1:0] r;
    logic [LEVEL_W-1:0] u;
  } obj_fields_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_PICK,
    ST_DIV_X,
    ST_DIV_Y,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_SAT,
    DIV_ITER
  } div_phase_t;

  typedef struct packed {
    logic take;
    logic clear;
    logic skip;
    logic next;
    logic div_start;
    logic div_sel_y;
    logic store_x;
    logic load_result;
    logic load_empty;
  } tplc_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic none_found;
    logic sel_found;
    logic div_done;
    logic out_taken;
    logic out_last;
  } tplc_status_t;

  function automatic obj_fields_t obj_fields(input logic [HALF_W-1:0] half);
    obj_fields_t f;
    f.flag = half[FLAG_R_BIT] | half[FLAG_U_BIT];
    f.r    = half[LEVEL_R_LSB +: LEVEL_W];
    f.u    = half[LEVEL_U_LSB +: LEVEL_W];
    return f;
  endfunction

  function automatic logic [OFFSET_W-1:0] level_offset(input logic [LEVEL_W-1:0] lvl);
    logic [OFFSET_W-1:0] off;
    if (lvl == '0) begin
      off = '0;
    end else begin
      off = OFFSET_W'(1) << (lvl - LEVEL_W'(1));
    end
    return off;
  endfunction

endpackage

@@ hw/rtl/tplc_divider.sv @@
// Iterative divider for the centroid core: one quotient bit per cycle, saturating.
// Forms the divisor as count times frame size, then yields floor(dividend * 2^16 / divisor).
// Depends on tplc_pkg.
module tplc_divider #(
  parameter int SW = 38,
  parameter int CW = 25,
  parameter int ZW = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [SW-1:0]                 dividend,
  input  logic [CW-1:0]                 count,
  input  logic [ZW-1:0]                 size,
  output logic                          done,
  output logic [tplc_pkg::CENTER_W-1:0] quotient
);
  import tplc_pkg::*;

  localparam int DW  = CW + ZW;
  localparam int XW  = (SW > DW + 1) ? SW : DW + 1;
  localparam int STW = $clog2(CENTER_W - 1);

  div_phase_t     phase;
  logic [SW-1:0]  num;
  logic [DW-1:0]  den;
  logic [DW-1:0]  rem;
  logic [STW-1:0] step;

  logic [XW-1:0]  num_x;
  logic [XW-1:0]  den_x;
  logic [XW-1:0]  den2_x;
  logic [XW-1:0]  diff_first;
  logic           sat;
  logic           ge_first;
  logic [DW:0]    rem2;
  logic [DW:0]    diff_iter;
  logic           ge_iter;

  always_comb begin
    num_x      = XW'(num);
    den_x      = XW'(den);
    den2_x     = XW'({den, 1'b0});
    sat        = num_x >= den2_x;
    ge_first   = num_x >= den_x;
    diff_first = num_x - den_x;
    rem2       = {rem, 1'b0};
    ge_iter    = rem2 >= {1'b0, den};
    diff_iter  = rem2 - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= DIV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        DIV_IDLE: begin
          if (start) begin
            phase <= DIV_SAT;
          end
        end
        DIV_SAT: begin
          if (sat) begin
            phase <= DIV_IDLE;
            done  <= 1'b1;
          end else begin
            phase <= DIV_ITER;
          end
        end
        DIV_ITER: begin
          if (step == '0) begin
            phase <= DIV_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          phase <= DIV_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      DIV_IDLE: begin
        if (start) begin
          num <= dividend;
          den <= {{ZW{1'b0}}, count} * {{CW{1'b0}}, size};
        end
      end
      DIV_SAT: begin
        quotient <= sat ? '1 : CENTER_W'(ge_first);
        rem      <= ge_first ? DW'(diff_first) : DW'(num_x);
        step     <= STW'(CENTER_W - 2);
      end
      DIV_ITER: begin
        quotient <= {quotient[CENTER_W-2:0], ge_iter};
        rem      <= ge_iter ? DW'(diff_iter) : DW'(rem2);
        step     <= step - STW'(1);
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/tplc_datapath.sv @@
// Datapath of the centroid core: frame registers, raster counters, per-object accumulators,
// the shared divider and the result register. Driven by commands from tplc_ctrl.
// Depends on tplc_pkg and tplc_divider.
module tplc_datapath #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tplc_pkg::tplc_cmd_t            cmd,
  output tplc_pkg::tplc_status_t         status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tplc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tplc_pkg::SIZE_W-1:0]    cfg_data,
  input  logic                           in_valid,
  input  logic [tplc_pkg::WORD_W-1:0]    pixel_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           found,
  output logic                           object_id,
  output logic                           slot_index,
  output logic [tplc_pkg::CENTER_W-1:0]  center_x,
  output logic [tplc_pkg::CENTER_W-1:0]  center_y,
  output logic [tplc_pkg::TOTAL_W-1:0]   object_total,
  output logic                           last
);
  import tplc_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int EXW   = $clog2(MAX_WIDTH + 1);
  localparam int EYW   = $clog2(MAX_HEIGHT + 1);
  localparam int ZW    = (EXW > EYW) ? EXW : EYW;
  localparam int MAXWH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int OW    = $clog2(MAXWH + OFFSET_MAX);
  localparam int CW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SW    = CW + OW;

  logic [SIZE_W-1:0]  frame_width;
  logic [SIZE_W-1:0]  frame_height;
  logic [XW-1:0]      column;
  logic [YW-1:0]      row;
  logic [LEVEL_W-1:0] peak [NUM_OBJ];
  logic [SW-1:0]      sum_x [NUM_OBJ];
  logic [SW-1:0]      sum_y [NUM_OBJ];
  logic [CW-1:0]      hit_count [NUM_OBJ];
  logic               obj_sel;
  logic               slot;
  logic [CENTER_W-1:0] center_x_hold;

  logic [EXW-1:0]     w_eff;
  logic [EYW-1:0]     h_eff;
  logic               col_last;
  logic               row_last;
  logic               pixel_fire;
  obj_fields_t        fields [NUM_OBJ];
  logic [LEVEL_W-1:0] level [NUM_OBJ];
  logic [OW-1:0]      add_x [NUM_OBJ];
  logic [OW-1:0]      add_y [NUM_OBJ];
  logic [NUM_OBJ-1:0] cnt_nz;
  logic               more;
  logic [TOTAL_W-1:0] total;
  logic [SW-1:0]      div_dividend;
  logic [ZW-1:0]      div_size;
  logic               div_done;
  logic [CENTER_W-1:0] div_quotient;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = EXW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_eff = EXW'(MAX_WIDTH);
    end else begin
      w_eff = EXW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = EYW'(1);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h_eff = EYW'(MAX_HEIGHT);
    end else begin
      h_eff = EYW'(frame_height);
    end
  end

  assign col_last   = (32'(column) + 32'd1) >= 32'(w_eff);
  assign row_last   = (32'(row) + 32'd1) >= 32'(h_eff);
  assign pixel_fire = cmd.take && in_valid;

  always_comb begin
    for (int k = 0; k < NUM_OBJ; k++) begin
      fields[k] = obj_fields(pixel_word[k*HALF_W +: HALF_W]);
      level[k]  = (fields[k].r > fields[k].u) ? fields[k].r : fields[k].u;
      add_x[k]  = OW'(column) + OW'(level_offset(fields[k].r));
      add_y[k]  = OW'(row) + OW'(level_offset(fields[k].u));
      cnt_nz[k] = hit_count[k] != '0;
    end
  end

  assign more  = !obj_sel && cnt_nz[1];
  assign total = TOTAL_W'(cnt_nz[0]) + TOTAL_W'(cnt_nz[1]);

  always_comb begin
    status.frame_done = in_valid && col_last && row_last;
    status.none_found = cnt_nz == '0;
    status.sel_found  = cnt_nz[obj_sel];
    status.div_done   = div_done;
    status.out_taken  = out_valid && !out_stall;
    status.out_last   = last;
  end

  assign div_dividend = cmd.div_sel_y ? sum_y[obj_sel] : sum_x[obj_sel];
  assign div_size     = cmd.div_sel_y ? ZW'(h_eff) : ZW'(w_eff);

  tplc_divider #(
    .SW(SW),
    .CW(CW),
    .ZW(ZW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .count    (hit_count[obj_sel]),
    .size     (div_size),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
      column       <= '0;
      row          <= '0;
      obj_sel      <= 1'b0;
      slot         <= 1'b0;
      out_valid    <= 1'b0;
      for (int k = 0; k < NUM_OBJ; k++) begin
        peak[k]      <= PEAK_START;
        sum_x[k]     <= '0;
        sum_y[k]     <= '0;
        hit_count[k] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
          CFG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
      if (pixel_fire) begin
        if (col_last) begin
          column <= '0;
          row    <= row_last ? '0 : row + YW'(1);
        end else begin
          column <= column + XW'(1);
        end
        for (int k = 0; k < NUM_OBJ; k++) begin
          if (fields[k].flag) begin
            if (level[k] > peak[k]) begin
              peak[k]      <= level[k];
              sum_x[k]     <= '0;
              sum_y[k]     <= '0;
              hit_count[k] <= '0;
            end else if (level[k] == peak[k]) begin
              sum_x[k]     <= sum_x[k] + SW'(add_x[k]);
              sum_y[k]     <= sum_y[k] + SW'(add_y[k]);
              hit_count[k] <= hit_count[k] + CW'(1);
            end
          end
        end
      end
      if (cmd.clear) begin
        obj_sel <= 1'b0;
        slot    <= 1'b0;
        for (int k = 0; k < NUM_OBJ; k++) begin
          peak[k]      <= PEAK_START;
          sum_x[k]     <= '0;
          sum_y[k]     <= '0;
          hit_count[k] <= '0;
        end
      end
      if (cmd.skip) begin
        obj_sel <= 1'b1;
      end
      if (cmd.next) begin
        obj_sel <= 1'b1;
        slot    <= 1'b1;
      end
      if (cmd.load_result || cmd.load_empty) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_x) begin
      center_x_hold <= div_quotient;
    end
    if (cmd.load_empty) begin
      found        <= 1'b0;
      object_id    <= 1'b0;
      slot_index   <= 1'b0;
      center_x     <= '0;
      center_y     <= '0;
      object_total <= '0;
      last         <= 1'b1;
    end else if (cmd.load_result) begin
      found        <= 1'b1;
      object_id    <= obj_sel;
      slot_index   <= slot;
      center_x     <= center_x_hold;
      center_y     <= div_quotient;
      object_total <= total;
      last         <= !more;
    end
  end

  a_peak_nonzero: assert property (@(posedge clk) disable iff (rst)
    peak[0] != '0 && peak[1] != '0)
    else $error("Peak level of an object fell to zero.");

  a_no_pixel_with_result: assert property (@(posedge clk) disable iff (rst)
    pixel_fire |-> !out_valid)
    else $error("Pixel transfer taken while a result was pending.");

  a_frame_end_wraps: assert property (@(posedge clk) disable iff (rst)
    (pixel_fire && status.frame_done) |=> (column == '0 && row == '0))
    else $error("Raster counters did not wrap at frame end.");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (TOTAL_W'(slot_index) < object_total))
    else $error("Result slot lies outside the object total.");

endmodule

@@ hw/rtl/tplc_ctrl.sv @@
// Controller of the centroid core: accumulates pixels, then sequences the divisions
// and result transfers at frame end. Drives the datapath by the command struct.
// Depends on tplc_pkg.
module tplc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  tplc_pkg::tplc_status_t status,
  output tplc_pkg::tplc_cmd_t    cmd
);
  import tplc_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCUM: begin
        if (status.frame_done) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        if (status.none_found) begin
          state_next = ST_EMIT;
        end else if (status.sel_found) begin
          state_next = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        if (status.div_done) begin
          state_next = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_taken) begin
          state_next = status.out_last ? ST_ACCUM : ST_PICK;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_ACCUM: begin
        cmd.take = !rst;
      end
      ST_PICK: begin
        if (status.none_found) begin
          cmd.load_empty = 1'b1;
        end else if (status.sel_found) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.skip = 1'b1;
        end
      end
      ST_DIV_X: begin
        if (status.div_done) begin
          cmd.store_x   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel_y = 1'b1;
        end
      end
      ST_DIV_Y: begin
        cmd.div_sel_y = 1'b1;
        if (status.div_done) begin
          cmd.load_result = 1'b1;
        end
      end
      ST_EMIT: begin
        if (status.out_taken) begin
          cmd.clear = status.out_last;
          cmd.next  = !status.out_last;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/two_object_peak_level_centroid_core.sv @@
// Top level of the two-object peak-level centroid core.
// Joins the controller and the datapath; depends on tplc_pkg, tplc_ctrl and tplc_datapath.
//
// Pixels arrive in raster order, one transfer per cycle while a frame is being collected;
// the core counts column and row itself from frame_width and frame_height. After the last
// pixel of a frame the core holds in_stall high while it works out the results: each found
// object needs two divisions on the shared divider, each of which loads the operands and
// forms count times size, makes a saturation check and then forms sixteen more quotient
// bits, or ends at the saturation check when the quotient saturates. When the low-half
// object is absent the core first skips on to the other object, and each result is held
// until the result side takes it. Configuration writes are always accepted and should be
// made between frames.
module two_object_peak_level_centroid_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tplc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tplc_pkg::SIZE_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tplc_pkg::WORD_W-1:0]    pixel_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           found,
  output logic                           object_id,
  output logic                           slot_index,
  output logic [tplc_pkg::CENTER_W-1:0]  center_x,
  output logic [tplc_pkg::CENTER_W-1:0]  center_y,
  output logic [tplc_pkg::TOTAL_W-1:0]   object_total,
  output logic                           last
);
  import tplc_pkg::*;

  tplc_cmd_t    cmd;
  tplc_status_t status;

  assign in_stall = !cmd.take;

  tplc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  tplc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .pixel_word   (pixel_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .object_id    (object_id),
    .slot_index   (slot_index),
    .center_x     (center_x),
    .center_y     (center_y),
    .object_total (object_total),
    .last         (last)
  );

endmodule
